// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/vgmi_pkg.sv =====
`default_nettype none

package vgmi_pkg;

   // Field widths.
   localparam int LEVEL_W    = 12;
   localparam int SECONDS_W  = 4;
   localparam int REQ_TYPE_W = 2;
   localparam int MODE_W     = 3;
   localparam int CSR_IDX_W  = 2;

   // Request kinds.
   localparam logic [REQ_TYPE_W-1:0] OP_GEAR_CHECK  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_LIGHT_CHECK = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_SECOND_TICK = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_MODE_TICK   = 2'd3;

   // Vehicle modes.
   localparam logic [MODE_W-1:0] MODE_POWERON = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LVCHECK = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HVCHECK = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READY   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DRIVING = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_ARM_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_ON_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_OFF_LEVEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUZZER_SECONDS  = 2'd3;

   // Register reset values.
   localparam logic [LEVEL_W-1:0]   BRAKE_ARM_LEVEL_RST = 12'd410;
   localparam logic [LEVEL_W-1:0]   LIGHT_ON_LEVEL_RST  = 12'd819;
   localparam logic [LEVEL_W-1:0]   LIGHT_OFF_LEVEL_RST = 12'd410;
   localparam logic [SECONDS_W-1:0] BUZZER_SECONDS_RST  = 4'd3;

   // The buzzer second counter saturates here.
   localparam logic [SECONDS_W-1:0] BUZZ_COUNT_MAX = 4'hF;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [LEVEL_W-1:0]    brake_level;
      logic                  gear_switch;
      logic                  tractive_enable;
      logic                  low_voltage_fault;
   } req_payload_type;

   typedef struct packed {
      logic              in_drive;
      logic [MODE_W-1:0] mode;
      logic              buzzer_active;
      logic              stop_lamp_lit;
   } rsp_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   brake_arm_level;
      logic [LEVEL_W-1:0]   light_on_level;
      logic [LEVEL_W-1:0]   light_off_level;
      logic [SECONDS_W-1:0] buzzer_seconds;
   } cfg_type;

   // A request after classification: the brake comparisons are already done.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0] op;
      logic                  above_arm;
      logic                  above_on;
      logic                  below_off;
      logic                  gear_switch;
      logic                  tractive_enable;
      logic                  low_voltage_fault;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vgmi_front.sv =====
`default_nettype none

module vgmi_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [vgmi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [vgmi_pkg::LEVEL_W-1:0]     csr_wdata,
   input  wire logic                             req_valid,
   input  wire vgmi_pkg::req_payload_type        req_payload,
   output logic                                  req_stall,
   input  wire vgmi_pkg::queue_status_type       q_status,
   output logic                                  q_push,
   output vgmi_pkg::item_type                    q_item,
   output vgmi_pkg::cfg_type                     cfg
);

   vgmi_pkg::cfg_type cfg_ff;
   vgmi_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            vgmi_pkg::CSR_BRAKE_ARM_LEVEL: cfg_in.brake_arm_level = csr_wdata;
            vgmi_pkg::CSR_LIGHT_ON_LEVEL:  cfg_in.light_on_level  = csr_wdata;
            vgmi_pkg::CSR_LIGHT_OFF_LEVEL: cfg_in.light_off_level = csr_wdata;
            vgmi_pkg::CSR_BUZZER_SECONDS:
               cfg_in.buzzer_seconds = csr_wdata[vgmi_pkg::SECONDS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brake_arm_level <= vgmi_pkg::BRAKE_ARM_LEVEL_RST;
         cfg_ff.light_on_level  <= vgmi_pkg::LIGHT_ON_LEVEL_RST;
         cfg_ff.light_off_level <= vgmi_pkg::LIGHT_OFF_LEVEL_RST;
         cfg_ff.buzzer_seconds  <= vgmi_pkg::BUZZER_SECONDS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify the request: compare the brake level against all thresholds.
   always_comb begin
      q_item.op                = req_payload.req_type;
      q_item.above_arm         = req_payload.brake_level > cfg_ff.brake_arm_level;
      q_item.above_on          = req_payload.brake_level > cfg_ff.light_on_level;
      q_item.below_off         = req_payload.brake_level < cfg_ff.light_off_level;
      q_item.gear_switch       = req_payload.gear_switch;
      q_item.tractive_enable   = req_payload.tractive_enable;
      q_item.low_voltage_fault = req_payload.low_voltage_fault;
   end

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;
   assign cfg       = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vgmi_queue.sv =====
`default_nettype none

module vgmi_queue #(
   parameter int DEPTH = vgmi_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire vgmi_pkg::item_type         push_item,
   input  wire logic                       pop,
   output vgmi_pkg::item_type              head_item,
   output vgmi_pkg::queue_status_type      status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vgmi_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/vgmi_back.sv =====
`default_nettype none

module vgmi_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire vgmi_pkg::cfg_type             cfg,
   input  wire vgmi_pkg::queue_status_type    q_status,
   input  wire vgmi_pkg::item_type            q_item,
   output logic                               q_pop,
   output logic                               rsp_valid,
   output vgmi_pkg::rsp_payload_type          rsp_payload,
   input  wire logic                          rsp_stall
);

   logic                               drive_ff, drive_in;
   logic                               armed_ff, armed_in;
   logic [vgmi_pkg::SECONDS_W-1:0]     count_ff, count_in;
   logic                               buzz_ff, buzz_in;
   logic                               light_ff, light_in;
   logic [vgmi_pkg::MODE_W-1:0]        mode_ff, mode_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   vgmi_pkg::rsp_payload_type          rsp_ff, rsp_in;
   logic                               armed_now;
   logic [vgmi_pkg::SECONDS_W-1:0]     count_step;

   // Take the head item whenever the output register is free or being drained.
   assign q_pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      drive_in  = drive_ff;
      armed_in  = armed_ff;
      count_in  = count_ff;
      buzz_in   = buzz_ff;
      light_in  = light_ff;
      mode_in   = mode_ff;
      armed_now = armed_ff || (q_item.above_arm && !q_item.gear_switch);
      count_step = (count_ff == vgmi_pkg::BUZZ_COUNT_MAX) ? count_ff : count_ff + 1'b1;

      case (q_item.op)
         vgmi_pkg::OP_GEAR_CHECK: begin
            if (!drive_ff) begin
               if (armed_now && q_item.gear_switch && q_item.tractive_enable) begin
                  drive_in = 1'b1;
                  armed_in = 1'b0;
                  count_in = '0;
                  buzz_in  = 1'b1;
               end else begin
                  armed_in = armed_now && !q_item.below_off;
               end
            end else if (!q_item.gear_switch) begin
               drive_in = 1'b0;
               count_in = '0;
               buzz_in  = 1'b0;
            end
         end
         vgmi_pkg::OP_LIGHT_CHECK: begin
            if (q_item.above_on) begin
               light_in = 1'b1;
            end else if (q_item.below_off) begin
               light_in = 1'b0;
            end
         end
         vgmi_pkg::OP_SECOND_TICK: begin
            if (drive_ff) begin
               count_in = count_step;
               if (count_step >= cfg.buzzer_seconds) begin
                  buzz_in = 1'b0;
               end
            end
         end
         vgmi_pkg::OP_MODE_TICK: begin
            if (mode_ff > vgmi_pkg::MODE_DRIVING) begin
               mode_in = vgmi_pkg::MODE_POWERON;
            end else if ((mode_ff == vgmi_pkg::MODE_POWERON ||
                          mode_ff == vgmi_pkg::MODE_LVCHECK) &&
                         q_item.low_voltage_fault) begin
               mode_in = vgmi_pkg::MODE_LVCHECK;
            end else begin
               mode_in = drive_ff ? vgmi_pkg::MODE_DRIVING : vgmi_pkg::MODE_READY;
            end
         end
         default: mode_in = mode_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (q_pop) begin
         rsp_valid_in         = 1'b1;
         rsp_in.in_drive      = drive_in;
         rsp_in.mode          = mode_in;
         rsp_in.buzzer_active = buzz_in;
         rsp_in.stop_lamp_lit = light_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff     <= 1'b0;
         armed_ff     <= 1'b0;
         count_ff     <= '0;
         buzz_ff      <= 1'b0;
         light_ff     <= 1'b0;
         mode_ff      <= vgmi_pkg::MODE_POWERON;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            drive_ff <= drive_in;
            armed_ff <= armed_in;
            count_ff <= count_in;
            buzz_ff  <= buzz_in;
            light_ff <= light_in;
            mode_ff  <= mode_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/vehicle_gear_and_mode_interlock_core.sv =====
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_payload (req_payload_type)
// rsp       out        rsp_valid/rsp_stall rsp_payload (rsp_payload_type)
// csr       in         csr_wr_en           csr_index, csr_wdata
//
// One request is accepted per cycle unless the queue is full, and yields exactly one response. The front
// end classifies it in the cycle it is accepted and writes it into the queue; the back end
// pops it once the response register is free or being drained and loads the response register,
// which then offers the response until it is taken. The back end updates the vehicle state as it
// pops each item, so the queue drains at one request per clock while the response is not stalled.
// Reset is synchronous and returns the registers to their defaults and the vehicle
// state to park and power on. A stalled response only backs up into the queue;
// requests stall once the queue is full.
`default_nettype none

`include "assert_macros.svh"

module vehicle_gear_and_mode_interlock_core #(
   parameter int QUEUE_DEPTH = vgmi_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [vgmi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vgmi_pkg::LEVEL_W-1:0]    csr_wdata,
   input  wire logic                            req_valid,
   input  wire vgmi_pkg::req_payload_type       req_payload,
   output logic                                 req_stall,
   output logic                                 rsp_valid,
   output vgmi_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                            rsp_stall
);

   vgmi_pkg::cfg_type          cfg;
   vgmi_pkg::queue_status_type q_status;
   vgmi_pkg::item_type         push_item;
   vgmi_pkg::item_type         head_item;
   logic                       q_push;
   logic                       q_pop;

   // The front end holds the registers and turns each request into a queue entry.
   vgmi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (push_item),
      .cfg         (cfg)
   );

   // The queue decouples request acceptance from response back-pressure.
   vgmi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // The back end owns the vehicle state and the response register.
   vgmi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_status    (q_status),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

   // A queued request reaches the response register as soon as it is free.
   `ASSERT_NEXT(a_queue_drains, clock, reset, !q_status.empty && !rsp_valid, rsp_valid)
   // A push into an empty queue leaves it occupied in the next cycle.
   `ASSERT_NEXT(a_push_lands, clock, reset, q_status.empty && q_push, !q_status.empty)
   // The mode machine never produces an unused code.
   `ASSERT_IMPLIES(a_mode_legal, clock, reset, rsp_valid, rsp_payload.mode <= vgmi_pkg::MODE_DRIVING)
   // The buzzer can only sound while the gear is in drive.
   `ASSERT_IMPLIES(a_buzz_in_drive, clock, reset, rsp_valid && !rsp_payload.in_drive, !rsp_payload.buzzer_active)

endmodule

`default_nettype wire
